// File: hdl/psdmx_pkg.sv
`timescale 1ns / 1ps

package psdmx_pkg;

  // Stream ids that follow the 00 00 01 start code prefix.
  localparam logic [7:0] ID_PACK    = 8'hBA;
  localparam logic [7:0] ID_SYSTEM  = 8'hBB;
  localparam logic [7:0] ID_MAP     = 8'hBC;
  localparam logic [7:0] ID_VIDEO   = 8'hE0;
  localparam logic [7:0] ID_AUDIO   = 8'hC0;
  localparam logic [7:0] ID_PRIVATE = 8'hBD;

  localparam logic [23:0] START_PREFIX = 24'h000001;

  // The pack header has ten bytes after its id; the last one carries the stuffing length.
  localparam logic [3:0] PACK_LAST_IDX = 4'd9;

  localparam logic [1:0] KIND_VIDEO   = 2'd0;
  localparam logic [1:0] KIND_AUDIO   = 2'd1;
  localparam logic [1:0] KIND_PRIVATE = 2'd2;

  typedef enum logic [12:0] {
    PH_HUNT     = 13'b0_0000_0000_0001,
    PH_PACK     = 13'b0_0000_0000_0010,
    PH_STUFF    = 13'b0_0000_0000_0100,
    PH_SYS_HI   = 13'b0_0000_0000_1000,
    PH_SYS_LO   = 13'b0_0000_0001_0000,
    PH_SYS_SKIP = 13'b0_0000_0010_0000,
    PH_PES_HI   = 13'b0_0000_0100_0000,
    PH_PES_LO   = 13'b0_0000_1000_0000,
    PH_FLAG1    = 13'b0_0001_0000_0000,
    PH_FLAG2    = 13'b0_0010_0000_0000,
    PH_HDRLEN   = 13'b0_0100_0000_0000,
    PH_HDRSKIP  = 13'b0_1000_0000_0000,
    PH_PAYLOAD  = 13'b1_0000_0000_0000
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

endpackage

// File: hdl/program_stream_pes_demux.sv
`timescale 1ns / 1ps

// Byte-serial MPEG-2 program stream demultiplexer.
// Input channel: stream_byte_i with stream_valid_i / stream_ready_o, one stream
// byte per beat. Output channel: payload_byte_o, stream_kind_o and packet_end_o
// with result_valid_o / result_ready_i, one elementary stream payload byte per beat.
// The block hunts for 00 00 01 start codes, skips pack headers, system headers
// and stream maps, reads the PES packet length and optional header of video (E0),
// audio (C0) and private (BD) packets, and forwards only their payload bytes.
// Header and skipped bytes are consumed and produce no output beat.
// An accepted byte is held in an input register, is parsed by a single
// level of state machine logic and its payload beat lands in the output register,
// so a result passes through both registers before it is valid on the output.
// Throughput is one byte per clock while the receiver keeps taking output beats.
// When the receiver stalls, the output register holds its beat and the input
// register still holds one more byte; stream_ready_o drops only while both are full.
// Reset clears both registers and returns the parser to start code hunting
// with an all-ones start code window.
module program_stream_pes_demux import psdmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       stream_valid_i,
  output logic       stream_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       result_valid_o,
  input  logic       result_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [1:0] stream_kind_o,
  output logic       packet_end_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       step;
  result_t    result;

  // The parser advances whenever a byte is held and the output register can take
  // whatever that byte produces.
  assign step           = in_valid_q && (!result_valid_o || result_ready_i);
  assign stream_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stream_ready_o) begin
      in_valid_q <= stream_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_ready_o && stream_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  psdmx_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  psdmx_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (result),
    .ready_i  (result_ready_i),
    .valid_o  (result_valid_o),
    .data_o   (payload_byte_o),
    .kind_o   (stream_kind_o),
    .last_o   (packet_end_o)
  );

endmodule

// File: hdl/psdmx_parser.sv
`timescale 1ns / 1ps

module psdmx_parser import psdmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  phase_e      phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [15:0] remain_q, remain_d;
  logic [7:0]  skip_q, skip_d;
  logic [1:0]  kind_q, kind_d;
  logic [3:0]  idx_q, idx_d;

  logic [15:0] remain_dec;
  logic [7:0]  skip_dec;
  logic        found;

  assign remain_dec = remain_q - 16'd1;
  assign skip_dec   = skip_q - 8'd1;
  assign found      = (window_q == START_PREFIX);

  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    remain_d = remain_q;
    skip_d   = skip_q;
    kind_d   = kind_q;
    idx_d    = idx_q;
    result_o = '0;
    result_o.data = byte_i;
    result_o.kind = kind_q;

    unique case (phase_q)
      PH_PACK: begin
        if (idx_q >= PACK_LAST_IDX) begin
          idx_d  = '0;
          skip_d = {5'd0, byte_i[2:0]};
          if (byte_i[2:0] == 3'd0) begin
            phase_d  = PH_HUNT;
            window_d = '1;
          end else begin
            phase_d = PH_STUFF;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      PH_STUFF: begin
        skip_d = skip_dec;
        if (skip_dec == 8'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end
      end
      PH_SYS_HI, PH_PES_HI: begin
        remain_d = {byte_i, 8'd0};
        phase_d  = (phase_q == PH_SYS_HI) ? PH_SYS_LO : PH_PES_LO;
      end
      PH_SYS_LO, PH_PES_LO: begin
        remain_d = {remain_q[15:8], byte_i};
        if ({remain_q[15:8], byte_i} == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end else begin
          phase_d = (phase_q == PH_SYS_LO) ? PH_SYS_SKIP : PH_FLAG1;
        end
      end
      PH_SYS_SKIP: begin
        remain_d = remain_dec;
        if (remain_dec == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end
      end
      PH_FLAG1, PH_FLAG2: begin
        remain_d = remain_dec;
        if (remain_dec == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end else begin
          phase_d = (phase_q == PH_FLAG1) ? PH_FLAG2 : PH_HDRLEN;
        end
      end
      PH_HDRLEN: begin
        remain_d = remain_dec;
        skip_d   = byte_i;
        if (remain_dec == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end else if (byte_i == 8'd0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HDRSKIP;
        end
      end
      PH_HDRSKIP: begin
        remain_d = remain_dec;
        skip_d   = skip_dec;
        if (remain_dec == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end else if (skip_dec == 8'd0) begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        remain_d        = remain_dec;
        result_o.valid  = step_i;
        result_o.last   = (remain_dec == 16'd0);
        if (remain_dec == 16'd0) begin
          phase_d  = PH_HUNT;
          window_d = '1;
        end
      end
      default: begin
        // Hunting; any phase code without meaning behaves the same way.
        phase_d = PH_HUNT;
        if (found && byte_i == ID_PACK) begin
          idx_d   = '0;
          phase_d = PH_PACK;
        end else if (found && (byte_i == ID_SYSTEM || byte_i == ID_MAP)) begin
          phase_d = PH_SYS_HI;
        end else if (found && (byte_i == ID_VIDEO || byte_i == ID_AUDIO ||
                               byte_i == ID_PRIVATE)) begin
          kind_d  = (byte_i == ID_VIDEO) ? KIND_VIDEO :
                    (byte_i == ID_AUDIO) ? KIND_AUDIO : KIND_PRIVATE;
          phase_d = PH_PES_HI;
        end
        if (phase_d == PH_HUNT) begin
          window_d = {window_q[15:0], byte_i};
        end else begin
          window_d = '1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      window_q <= '1;
      remain_q <= '0;
      skip_q   <= '0;
      kind_q   <= KIND_VIDEO;
      idx_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      window_q <= window_d;
      remain_q <= remain_d;
      skip_q   <= skip_d;
      kind_q   <= kind_d;
      idx_q    <= idx_d;
    end
  end

endmodule

// File: hdl/psdmx_out_reg.sv
`timescale 1ns / 1ps

module psdmx_out_reg import psdmx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    result_i,
  input  logic       ready_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic [1:0] kind_q;
  logic       last_q;

  // A load only happens when the register is empty or drained in this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= result_i.valid;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      data_q <= result_i.data;
      kind_q <= result_i.kind;
      last_q <= result_i.last;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign kind_o  = kind_q;
  assign last_o  = last_q;

endmodule

// File: hdl/psdmx_checker.sv
`timescale 1ns / 1ps

module psdmx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       stream_valid_i,
  input logic       stream_ready_o,
  input logic       result_valid_o,
  input logic       result_ready_i,
  input logic [7:0] payload_byte_o,
  input logic [1:0] stream_kind_o,
  input logic       packet_end_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o &&
    $stable(payload_byte_o) && $stable(stream_kind_o) && $stable(packet_end_o))
    else $error("output beat changed while stalled");

  // Only video, audio and private kinds are ever emitted.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> stream_kind_o != 2'd3)
    else $error("illegal stream kind");

  // Input back-pressure appears only while an output beat is stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stream_ready_o |-> result_valid_o && !result_ready_i)
    else $error("input stalled without output back-pressure");

  // With no bytes accepted, no new beat can appear.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stream_valid_i && stream_ready_o) ##1 !(stream_valid_i && stream_ready_o)
    ##1 !result_valid_o |=> !result_valid_o)
    else $error("output beat without an input byte");

endmodule

bind program_stream_pes_demux psdmx_checker u_psdmx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .stream_valid_i (stream_valid_i),
  .stream_ready_o (stream_ready_o),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .payload_byte_o (payload_byte_o),
  .stream_kind_o  (stream_kind_o),
  .packet_end_o   (packet_end_o)
);
